// ===== rtl/sidset_pkg.sv =====
// ----------------------------------------------------------------------------
// sidset_pkg: shared definitions for the sorted ID set
//
// Sizes, mode codes and the controller state type used by the sorted
// ID set and its table memory.
// ----------------------------------------------------------------------------
package sidset_pkg;

  // Number of IDs the table can hold.
  localparam int CAPACITY = 64;

  // Width of one stored ID.
  localparam int ID_W = 32;

  // Index into the table, and a count that can reach CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Item modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_SHIFT,
    S_INS,
    S_DONE
  } state_t;

endpackage

// ===== rtl/sidset_ram.sv =====
// ----------------------------------------------------------------------------
// sidset_ram: generic simple dual-port RAM
//
// One write port and one read port, with the read data registered.
// No reset on the contents.
// ----------------------------------------------------------------------------
module sidset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sorted_id_set_membership.sv =====
// ----------------------------------------------------------------------------
// sorted_id_set_membership: bounded sorted set of signed 32-bit IDs
//
// Each input word is a lookup or an insert of one ID; each gives one result
// word with present, stored and table_full.
// ----------------------------------------------------------------------------
// The block takes one word at a time. IDs live in ascending order in a single
// table RAM with one read and one write port and a registered read. A word
// first runs a binary search over the filled entries, each probe a read in
// S_SEARCH and then a compare in S_CMP. An insert of a new ID into a table
// that is not full then moves the entries above its slot up by one, one
// entry per cycle through the RAM's read and write ports, and writes the ID
// into the slot. S_DONE then loads the result register once that register is
// free or its result is being taken. The next word is taken as soon as the
// result is in the output register, even while that result still waits to be
// taken.
// The table needs no clearing after reset: entries above the fill count are
// never read.
module sorted_id_set_membership (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic signed [sidset_pkg::ID_W-1:0] id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         present,
  output logic                         stored,
  output logic                         table_full
);

  import sidset_pkg::*;

  state_t state, state_next;

  logic             in_accept;
  logic             out_accept;
  logic [ID_W-1:0]  key;
  logic             mode_r;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_calc;
  logic [CNT_W-1:0] k;
  logic             hit;
  logic             stored_r;
  logic             pend;
  logic [IDX_W-1:0] pend_addr;
  logic             search_go;
  logic             shift_go;
  logic             ins_needed;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ID_W-1:0]  ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ID_W-1:0]  ram_rdata;

  // Handshakes.
  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Search and shift conditions.
  assign mid_calc   = lo + ((hi - lo) >> 1);
  assign search_go  = (lo < hi);
  assign shift_go   = (k > lo);
  assign ins_needed = (mode_r == MODE_INSERT) && !hit && (count < CNT_W'(CAPACITY));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_go) begin
          state_next = S_CMP;
        end else if (ins_needed) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP: state_next = S_SEARCH;
      S_SHIFT: begin
        if (!shift_go) begin
          state_next = S_INS;
        end
      end
      S_INS: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table RAM controls.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    case (state)
      S_SEARCH: begin
        if (search_go) begin
          ram_re    = 1'b1;
          ram_raddr = mid_calc[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        if (shift_go) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(k - CNT_W'(1));
        end
        // Write back the entry read in the previous cycle, one slot higher.
        ram_we = pend;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = lo[IDX_W-1:0];
        ram_wdata = key;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  sidset_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SHIFT) && shift_go;
      if (state == S_INS) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Search bounds, key and shift pointer.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      // Flipping the sign bit makes unsigned order match signed order.
      key      <= {~id[ID_W-1], id[ID_W-2:0]};
      mode_r   <= mode;
      lo       <= '0;
      hi       <= count;
      k        <= count;
      hit      <= 1'b0;
      stored_r <= 1'b0;
    end else begin
      case (state)
        S_SEARCH: mid <= mid_calc;
        S_CMP: begin
          if (ram_rdata < key) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          if (ram_rdata == key) begin
            hit <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (shift_go) begin
            pend_addr <= k[IDX_W-1:0];
            k         <= k - CNT_W'(1);
          end
        end
        S_INS: stored_r <= 1'b1;
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      present    <= hit;
      stored     <= stored_r;
      table_full <= (mode_r == MODE_INSERT) && !hit && !stored_r;
    end
  end

  // The fill count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The search window never inverts.
  assert property (@(posedge clk) disable iff (rst) (state == S_SEARCH) |-> (lo <= hi))
    else $error("search bounds crossed");

  // An insert into the table bumps the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |=> (count == $past(count) + CNT_W'(1)))
    else $error("count not advanced by insert");

  // A result never claims both a store and a refusal, nor a store of a present ID.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stored && table_full) && !(stored && present))
    else $error("inconsistent result flags");

  // No pending shift write is left over when the new ID is written.
  assert property (@(posedge clk) disable iff (rst) (state == S_INS) |-> !pend)
    else $error("shift write pending at insert");

endmodule

// ===== verif/tb_sorted_id_set_membership.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_id_set_membership: self-checking bench for the sorted ID set
//
// Drives lookup and insert words into the block and predicts each result
// word from a sorted shadow copy of the set kept inside the bench. The run
// starts with the signed extremes and the duplicate case, holds the output
// off long enough to back the block up, runs random traffic under changing
// idle patterns, fills the table and probes it, then ends with more traffic.
// ----------------------------------------------------------------------------
module tb_sorted_id_set_membership;
  import sidset_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_LEN   = 200;
  localparam int PRINT_MAX   = 50;

  localparam logic signed [ID_W-1:0] ID_MIN = {1'b1, {(ID_W-1){1'b0}}};
  localparam logic signed [ID_W-1:0] ID_MAX = {1'b0, {(ID_W-1){1'b1}}};

  typedef struct packed {
    logic present;
    logic stored;
    logic table_full;
  } set_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   mode = MODE_LOOKUP;
  logic signed [ID_W-1:0] id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   present;
  logic                   stored;
  logic                   table_full;

  // Shadow of the set, ascending in entries 0 to member_count-1.
  logic signed [ID_W-1:0] members [CAPACITY];
  int                     member_count = 0;

  set_reply_t             pending_replies [$];
  int                     err_count = 0;
  int                     cycle_count = 0;
  int                     tx_idle_pct = 0;
  int                     rx_idle_pct = 0;
  int                     hold_seq = 0;
  int                     hold_seen = 0;
  int                     hold_left = 0;

  sorted_id_set_membership uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .id         (id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .present    (present),
    .stored     (stored),
    .table_full (table_full)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sorted_id_set_membership: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_MAX) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    err_count++;
  endtask

  // First slot whose ID is not below v, in signed order.
  function automatic int lower_slot(input logic signed [ID_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = member_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (members[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic is_member(input logic signed [ID_W-1:0] v);
    int pos;
    pos = lower_slot(v);
    return (pos < member_count) && (members[pos] == v);
  endfunction

  // Work out the reply to one word and update the shadow set.
  function automatic set_reply_t apply_to_set(input logic m,
                                              input logic signed [ID_W-1:0] v);
    set_reply_t r;
    int pos;
    pos = lower_slot(v);
    r.present = (pos < member_count) && (members[pos] == v);
    r.stored = 1'b0;
    r.table_full = 1'b0;
    if (m == MODE_INSERT && !r.present) begin
      if (member_count >= CAPACITY) begin
        r.table_full = 1'b1;
      end else begin
        for (int k = member_count; k > pos; k--) members[k] = members[k-1];
        members[pos] = v;
        member_count++;
        r.stored = 1'b1;
      end
    end
    return r;
  endfunction

  // An ID that is not in the set yet.
  function automatic logic signed [ID_W-1:0] fresh_id();
    logic signed [ID_W-1:0] v;
    v = $urandom();
    while (is_member(v)) v = $urandom();
    return v;
  endfunction

  // Random ID, weighted toward hits and near misses.
  function automatic logic signed [ID_W-1:0] pick_id(input int fresh_pct);
    int r;
    logic signed [ID_W-1:0] base;
    r = $urandom_range(0, 99);
    if (member_count == 0) return $urandom();
    base = members[$urandom_range(0, member_count - 1)];
    if (r < 40) return base;
    if (r < 50) return $urandom_range(0, 1) ? base + 1 : base - 1;
    if (r < 50 + fresh_pct) return $urandom();
    case ($urandom_range(0, 6))
      0: return ID_MIN;
      1: return ID_MAX;
      2: return ID_MIN + 1;
      3: return ID_MAX - 1;
      4: return -1;
      5: return 1;
      default: return 0;
    endcase
  endfunction

  // Offer one word, starting at a rising edge, and return at the edge that
  // takes it. The expectation is queued once the word is sure to be taken.
  task automatic send_word(input logic m, input logic signed [ID_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    id <= v;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    pending_replies.insert(pending_replies.size(), apply_to_set(m, v));
    @(posedge clk);
  endtask

  // Output side: random stall, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare every result word taken at the next edge with the oldest
  // expectation. Signals are stable at the falling edge.
  always @(negedge clk) begin
    set_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result word with no word outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (present !== want.present)
          report_mismatch($sformatf("present: expected %b, got %b",
                                    want.present, present));
        if (stored !== want.stored)
          report_mismatch($sformatf("stored: expected %b, got %b",
                                    want.stored, stored));
        if (table_full !== want.table_full)
          report_mismatch($sformatf("table_full: expected %b, got %b",
                                    want.table_full, table_full));
      end
    end
  end

  // Signed extremes, an empty table and duplicate inserts.
  task automatic test_directed_edges();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_word(MODE_LOOKUP, 0);
    send_word(MODE_LOOKUP, ID_MIN);
    send_word(MODE_INSERT, 0);
    send_word(MODE_INSERT, 0);
    send_word(MODE_INSERT, ID_MAX);
    send_word(MODE_INSERT, ID_MIN);
    send_word(MODE_LOOKUP, ID_MIN);
    send_word(MODE_LOOKUP, ID_MAX);
    send_word(MODE_LOOKUP, -1);
    send_word(MODE_LOOKUP, 1);
    send_word(MODE_INSERT, -1);
    send_word(MODE_INSERT, 1);
    send_word(MODE_INSERT, 32'sh5555_5555);
    send_word(MODE_INSERT, 32'shAAAA_AAAA);
    send_word(MODE_INSERT, ID_MIN + 1);
    send_word(MODE_INSERT, ID_MAX - 1);
    send_word(MODE_INSERT, ID_MIN);
    send_word(MODE_INSERT, ID_MAX);
    send_word(MODE_LOOKUP, 32'shAAAA_AAAA);
    send_word(MODE_LOOKUP, 32'sh5555_5554);
    send_word(MODE_LOOKUP, 0);
  endtask

  // Hold the output off while words keep coming, so the block backs up.
  task automatic test_back_pressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_seq = hold_seq + 1;
    for (int n = 0; n < 40; n++) begin
      send_word($urandom_range(0, 1) ? MODE_INSERT : MODE_LOOKUP, pick_id(25));
    end
  endtask

  // Random lookups and inserts under one idle pattern.
  task automatic test_random_mix(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      send_word(($urandom_range(0, 99) < 40) ? MODE_INSERT : MODE_LOOKUP, pick_id(25));
    end
  endtask

  // Fill the table if random traffic has not, then probe the full table.
  task automatic test_full_table();
    tx_idle_pct = 5;
    rx_idle_pct = 20;
    while (member_count < CAPACITY) send_word(MODE_INSERT, fresh_id());
    send_word(MODE_INSERT, fresh_id());
    send_word(MODE_INSERT, ID_MIN);
    send_word(MODE_INSERT, members[0]);
    send_word(MODE_INSERT, members[CAPACITY - 1]);
    send_word(MODE_LOOKUP, members[CAPACITY / 2]);
    send_word(MODE_LOOKUP, fresh_id());
    send_word(MODE_INSERT, fresh_id());
    send_word(MODE_LOOKUP, ID_MAX);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_back_pressure();
    test_random_mix(8, 54, 360);
    test_random_mix(54, 8, 360);
    test_full_table();
    test_random_mix(0, 0, 360);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_sorted_id_set_membership: done, clean");
    end else begin
      $display("tb_sorted_id_set_membership: done, errors");
    end
    $finish;
  end

endmodule
